/* hdl/ancb_pkg.sv */
// shared types, command codes and helpers for the active note chroma builder
// no dependencies
package ancb_pkg;

    localparam int NUM_CLASSES = 12;
    localparam logic [3:0] LAST_CLASS = 4'd11;
    localparam logic [12:0] WEIGHT_MAX = 13'd8191;
    localparam logic [6:0] COUNT_MAX = 7'd127;
    localparam logic [6:0] NOTE_TOP = 7'd127;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] note;
        logic [6:0] velocity;
    } msg_t;

    typedef struct packed {
        logic [3:0]  pitch_class;
        logic [12:0] weight_sum;
        logic [3:0]  bass_class;
        logic [6:0]  note_count;
        logic        overflow;
        logic        last;
    } chroma_t;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
    } entry_t;

    typedef struct packed {
        logic       clear;
        logic       add;
        logic [6:0] note;
        logic [6:0] vel;
    } acc_ctl_t;

    // note mod 12 through a reciprocal multiply, exact for 7-bit notes
    function automatic logic [3:0] mod12(input logic [6:0] n);
        logic [12:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {6'd0, n} * 13'd43;
        q = prod[12:9];
        r = n - ({q, 3'b000} + {1'b0, q, 2'b00});
        return r[3:0];
    endfunction

endpackage

/* hdl/ancb_msg_if.sv */
// input channel carrying note commands
// depends on ancb_pkg
interface ancb_msg_if;
    logic              valid;
    logic              ready;
    ancb_pkg::msg_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/ancb_chroma_if.sv */
// output channel carrying one chroma bin per transfer
// depends on ancb_pkg
interface ancb_chroma_if;
    logic              valid;
    logic              ready;
    ancb_pkg::chroma_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/ancb_chroma_acc.sv */
// per pitch class velocity sums and lowest note tracker, fed one entry a cycle
// depends on ancb_pkg
module ancb_chroma_acc
(
    input  logic               clk,
    input  ancb_pkg::acc_ctl_t ctl,
    input  logic [3:0]         sel,
    output logic [12:0]        weight,
    output logic [6:0]         lowest
);

    logic [12:0] sums_reg [ancb_pkg::NUM_CLASSES];
    logic [6:0]  lowest_reg;
    logic [3:0]  cls;
    logic [13:0] sum_wide;
    logic [12:0] sum_next;
    logic [6:0]  lowest_next;

    always_comb
    begin
        cls = ancb_pkg::mod12(ctl.note);
        sum_wide = {1'b0, sums_reg[cls]} + {7'd0, ctl.vel};
        sum_next = sum_wide[13] ? ancb_pkg::WEIGHT_MAX : sum_wide[12:0];
        lowest_next = (ctl.note < lowest_reg) ? ctl.note : lowest_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            for (int i = 0; i < ancb_pkg::NUM_CLASSES; i++)
            begin
                sums_reg[i] <= '0;
            end
            lowest_reg <= ancb_pkg::NOTE_TOP;
        end
        else if (ctl.add)
        begin
            sums_reg[cls] <= sum_next;
            lowest_reg <= lowest_next;
        end
    end

    assign weight = sums_reg[sel];
    assign lowest = lowest_reg;

endmodule

/* hdl/active_note_chroma_builder_unit.sv */
// top level of the active note chroma builder: note table memory and sequencer
// depends on ancb_pkg, ancb_msg_if, ancb_chroma_if and ancb_chroma_acc
//
// msg takes one command per transfer: note on, note off, clear or query.
// a note on with zero velocity acts as a note off.
// chroma gives twelve transfers per query, pitch classes 0 to 11, last on 11.
// note on and clear are done without leaving the idle state.
// note off scans the table from its memory, one entry per cycle over the
// single read port, later entries written one down.
// a query scans the same way into the per class sums, then sends one bin per
// cycle while chroma is ready.
// msg is ready only between commands; a stalled receiver holds the
// sequencer in the send phase, and the last bin may wait in the output
// register while the next command is taken.
// reset empties the table and clears the overflow flag at once; table
// contents are not cleared and need no pass.
module active_note_chroma_builder_unit
#(
    parameter int MAX_NOTES = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    ancb_msg_if.sink      msg,
    ancb_chroma_if.source chroma
);

    localparam int AW = $clog2(MAX_NOTES);
    localparam int CW = $clog2(MAX_NOTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_QUERY,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [6:0]         key_reg, key_next;
    logic               found_reg, found_next;
    logic [3:0]         cls_reg, cls_next;
    logic               out_valid_reg, out_valid_next;
    ancb_pkg::chroma_t  out_data_reg, out_data_next;

    ancb_pkg::entry_t   mem [MAX_NOTES];
    ancb_pkg::entry_t   rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    ancb_pkg::entry_t   mem_wdata;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    ancb_pkg::acc_ctl_t acc_ctl;
    logic [12:0]        acc_weight;
    logic [6:0]         acc_lowest;

    logic               last_data;
    logic               match;
    logic [8:0]         count_wide;

    ancb_chroma_acc u_acc
    (
        .clk    (clk),
        .ctl    (acc_ctl),
        .sel    (cls_reg),
        .weight (acc_weight),
        .lowest (acc_lowest)
    );

    assign msg.ready = (state_reg == S_IDLE);
    assign chroma.valid = out_valid_reg;
    assign chroma.data = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        overflow_next = overflow_reg;
        rd_idx_next = rd_idx_reg;
        pos_next = pos_reg;
        key_next = key_reg;
        found_next = found_reg;
        cls_next = cls_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        mem_we = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = '{note: msg.data.note, vel: msg.data.velocity};
        rd_en = 1'b0;
        rd_addr = rd_idx_reg[AW-1:0];
        acc_ctl = '{clear: 1'b0, add: 1'b0, note: rd_data_reg.note, vel: rd_data_reg.vel};
        last_data = rd_vld_reg && (CW'(pos_reg) == count_reg - 1'b1);
        match = (rd_data_reg.note == key_reg);
        count_wide = 9'(count_reg);

        if (chroma.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    rd_idx_next = '0;
                    found_next = 1'b0;
                    key_next = msg.data.note;
                    case (msg.data.cmd)
                        ancb_pkg::CMD_NOTE_ON,
                        ancb_pkg::CMD_NOTE_OFF:
                        begin
                            if (msg.data.cmd == ancb_pkg::CMD_NOTE_ON
                                && msg.data.velocity != 7'd0)
                            begin
                                if (count_reg < CW'(MAX_NOTES))
                                begin
                                    mem_we = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            else if (count_reg != '0)
                            begin
                                state_next = S_REMOVE;
                            end
                        end
                        ancb_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ancb_pkg::CMD_QUERY:
                        begin
                            acc_ctl.clear = 1'b1;
                            cls_next = '0;
                            state_next = (count_reg == '0) ? S_EMIT : S_QUERY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REMOVE, S_QUERY:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_en = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pos_next = rd_idx_reg[AW-1:0];
                end
                if (state_reg == S_REMOVE)
                begin
                    mem_waddr = pos_reg - 1'b1;
                    mem_wdata = rd_data_reg;
                    if (rd_vld_reg)
                    begin
                        if (found_reg)
                        begin
                            mem_we = 1'b1;
                        end
                        else if (match)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    if (last_data)
                    begin
                        if (found_reg || match)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    acc_ctl.add = rd_vld_reg;
                    if (last_data)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || chroma.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.pitch_class = cls_reg;
                    out_data_next.weight_sum = acc_weight;
                    out_data_next.bass_class = (count_reg != '0)
                        ? ancb_pkg::mod12(acc_lowest) : 4'd0;
                    out_data_next.note_count = (count_wide > 9'(ancb_pkg::COUNT_MAX))
                        ? ancb_pkg::COUNT_MAX : count_wide[6:0];
                    out_data_next.overflow = overflow_reg;
                    out_data_next.last = (cls_reg == ancb_pkg::LAST_CLASS);
                    if (cls_reg == ancb_pkg::LAST_CLASS)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_vld_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            overflow_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            overflow_reg <= overflow_next;
            rd_vld_reg <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
        found_reg <= found_next;
        cls_reg <= cls_next;
        out_data_reg <= out_data_next;
    end

    // note table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_NOTES))
        else $error("note count beyond table depth");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag dropped without reset");

    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REMOVE |=>
            (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) - 1'b1))
        else $error("removal changed the count by more than one");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        chroma.valid && chroma.data.last |-> chroma.data.pitch_class == ancb_pkg::LAST_CLASS)
        else $error("last flag on a bin other than the final class");

    a_no_take_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !msg.ready)
        else $error("command taken while bins remain to send");
`endif

endmodule

/* tb/active_note_chroma_builder_unit_test.sv */
`timescale 1ns / 100ps
// testbench for active_note_chroma_builder_unit: directed table then random note traffic,
// chroma bins checked against typed answers in the directed table or a behavioural note table kept here
// depends on ancb_pkg, ancb_msg_if, ancb_chroma_if and the rtl top level
module active_note_chroma_builder_unit_test;

    localparam int TABLE_DEPTH = 64;
    localparam int RUN_ITEMS = 420;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int IDLE_LIMIT = 3000;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        ancb_pkg::cmd_t cmd;
        logic [6:0]     note;
        logic [6:0]     vel;
        logic           typed;
        logic [6:0]     t_count;
        logic [3:0]     t_bass;
        logic           t_ovf;
        logic [3:0]     t_class;
        logic [12:0]    t_weight;
    } stim_row_t;

    // typed rows carry the whole query answer: one class holds the weight, the rest are zero
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b1, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd127, 7'd127, 1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b1, 7'd1, 4'd7, 1'b0, 4'd7, 13'd127},
        '{ancb_pkg::CMD_NOTE_OFF, 7'd127, 7'd85,  1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b1, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd0,   7'd1,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd0,   7'd127, 1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd60,  7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_OFF, 7'd0,   7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b1, 7'd1, 4'd0, 1'b0, 4'd0, 13'd127},
        '{ancb_pkg::CMD_NOTE_OFF, 7'd5,   7'd127, 1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd12,  7'd64,  1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd24,  7'd3,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd127, 7'd42,  1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd1,   7'd100, 1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd33,  7'd99,  1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd12,  7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_OFF, 7'd127, 7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_CLEAR,    7'd127, 7'd127, 1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd127, 7'd127, 1'b1, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_OFF, 7'd0,   7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_NOTE_ON,  7'd85,  7'd85,  1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0},
        '{ancb_pkg::CMD_QUERY,    7'd0,   7'd0,   1'b1, 7'd1, 4'd1, 1'b0, 4'd1, 13'd85},
        '{ancb_pkg::CMD_CLEAR,    7'd0,   7'd0,   1'b0, 7'd0, 4'd0, 1'b0, 4'd0, 13'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ancb_msg_if    msg_ch ();
    ancb_chroma_if bin_ch ();

    active_note_chroma_builder_unit #(
        .MAX_NOTES (TABLE_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .chroma (bin_ch)
    );

    always #5 clk = ~clk;

    logic [6:0]        sounding_note [TABLE_DEPTH];
    logic [6:0]        sounding_vel [TABLE_DEPTH];
    int                sounding_total = 0;
    bit                drop_latched = 1'b0;
    ancb_pkg::chroma_t pending_bins [$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned idle_cycles = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    bit          hold_request = 1'b0;

    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic queue_bin(input ancb_pkg::chroma_t b);
        pending_bins = {pending_bins, b};
    endtask

    // mirror of the note table; a query queues its twelve chroma bins
    task automatic track_command(input ancb_pkg::msg_t m);
        int unsigned       class_sum [ancb_pkg::NUM_CLASSES];
        int unsigned       lowest;
        int                hit;
        ancb_pkg::chroma_t bin;
        hit = -1;
        lowest = 128;
        if (m.cmd == ancb_pkg::CMD_NOTE_ON && m.velocity != 7'd0)
        begin
            if (sounding_total < TABLE_DEPTH)
            begin
                sounding_note[sounding_total] = m.note;
                sounding_vel[sounding_total] = m.velocity;
                sounding_total++;
            end
            else
                drop_latched = 1'b1;
        end
        else if (m.cmd == ancb_pkg::CMD_NOTE_ON || m.cmd == ancb_pkg::CMD_NOTE_OFF)
        begin
            for (int i = 0; i < sounding_total; i++)
                if (hit < 0 && sounding_note[i] == m.note)
                    hit = i;
            if (hit >= 0)
            begin
                for (int j = hit; j < sounding_total - 1; j++)
                begin
                    sounding_note[j] = sounding_note[j + 1];
                    sounding_vel[j] = sounding_vel[j + 1];
                end
                sounding_total--;
            end
        end
        else if (m.cmd == ancb_pkg::CMD_CLEAR)
            sounding_total = 0;
        else
        begin
            foreach (class_sum[c])
                class_sum[c] = 0;
            for (int i = 0; i < sounding_total; i++)
            begin
                if (sounding_note[i] < lowest)
                    lowest = sounding_note[i];
                class_sum[sounding_note[i] % ancb_pkg::NUM_CLASSES] += sounding_vel[i];
            end
            for (int c = 0; c < ancb_pkg::NUM_CLASSES; c++)
            begin
                bin.pitch_class = 4'(c);
                bin.weight_sum = (class_sum[c] > 8191)
                    ? ancb_pkg::WEIGHT_MAX : 13'(class_sum[c]);
                bin.bass_class = (sounding_total != 0)
                    ? 4'(lowest % ancb_pkg::NUM_CLASSES) : 4'd0;
                bin.note_count = (sounding_total > 127)
                    ? ancb_pkg::COUNT_MAX : 7'(sounding_total);
                bin.overflow = drop_latched;
                bin.last = (c == ancb_pkg::NUM_CLASSES - 1);
                queue_bin(bin);
            end
        end
    endtask

    task automatic send_item(input ancb_pkg::cmd_t c, input logic [6:0] n,
                             input logic [6:0] v, input bit from_model);
        int unsigned    gap;
        ancb_pkg::msg_t m;
        m.cmd = c;
        m.note = n;
        m.velocity = v;
        gap = draw_wait(send_calm);
        if (gap != 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.data <= m;
        do @(posedge clk); while (msg_ch.ready !== 1'b1);
        if (from_model)
            track_command(m);
        items_sent++;
    endtask

    task automatic drain_results;
        msg_ch.valid <= 1'b0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // stimulus
    initial
    begin
        int unsigned       k;
        int unsigned       pc;
        int unsigned       kind;
        logic [6:0]        n;
        bit                paused;
        bit                first_fill;
        bit                one_class;
        ancb_pkg::chroma_t bin;
        paused = 1'b0;
        first_fill = 1'b1;
        rst_n <= 1'b0;
        msg_ch.valid <= 1'b0;
        msg_ch.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].typed)
            begin
                for (int c = 0; c < ancb_pkg::NUM_CLASSES; c++)
                begin
                    bin.pitch_class = 4'(c);
                    bin.weight_sum = (4'(c) == DIRECTED[r].t_class)
                        ? DIRECTED[r].t_weight : 13'd0;
                    bin.bass_class = DIRECTED[r].t_bass;
                    bin.note_count = DIRECTED[r].t_count;
                    bin.overflow = DIRECTED[r].t_ovf;
                    bin.last = (c == ancb_pkg::NUM_CLASSES - 1);
                    queue_bin(bin);
                end
            end
            send_item(DIRECTED[r].cmd, DIRECTED[r].note, DIRECTED[r].vel, !DIRECTED[r].typed);
        end
        drain_results();

        // receiver holds off while queries keep arriving
        hold_request = 1'b1;
        repeat (3)
            send_item(ancb_pkg::CMD_NOTE_ON, 7'($urandom), 7'($urandom_range(1, 127)), 1'b1);
        repeat (4)
            send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
        send_item(ancb_pkg::CMD_NOTE_OFF, sounding_note[0], 7'($urandom), 1'b1);
        send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);

        while (items_sent < RUN_ITEMS)
        begin
            if (!paused && items_sent > RUN_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            kind = first_fill ? 0 : $urandom_range(0, 19);
            if (kind == 0)
            begin
                // fill the table, push it past full, then query, drop three notes, query again and clear
                pc = $urandom_range(0, 11);
                one_class = first_fill || ($urandom_range(0, 1) == 1);
                first_fill = 1'b0;
                while (sounding_total < TABLE_DEPTH)
                begin
                    if (one_class)
                        send_item(ancb_pkg::CMD_NOTE_ON,
                                  7'(pc + 12 * $urandom_range(0, (127 - pc) / 12)),
                                  7'd127, 1'b1);
                    else
                        send_item(ancb_pkg::CMD_NOTE_ON, 7'($urandom),
                                  7'($urandom_range(1, 127)), 1'b1);
                end
                repeat ($urandom_range(1, 3))
                    send_item(ancb_pkg::CMD_NOTE_ON, 7'($urandom),
                              7'($urandom_range(1, 127)), 1'b1);
                send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
                repeat (3)
                    send_item(ancb_pkg::CMD_NOTE_OFF,
                              sounding_note[$urandom_range(0, sounding_total - 1)],
                              7'($urandom), 1'b1);
                send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
                send_item(ancb_pkg::CMD_CLEAR, 7'($urandom), 7'($urandom), 1'b1);
            end
            else if (kind < 14)
            begin
                k = $urandom_range(1, 6);
                if (sounding_total > 48)
                    send_item(ancb_pkg::CMD_CLEAR, 7'($urandom), 7'($urandom), 1'b1);
                repeat (k)
                begin
                    if (sounding_total != 0 && $urandom_range(0, 3) == 0)
                        n = sounding_note[$urandom_range(0, sounding_total - 1)];
                    else
                        n = 7'($urandom);
                    send_item(ancb_pkg::CMD_NOTE_ON, n, 7'($urandom_range(1, 127)), 1'b1);
                end
                send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
                repeat ($urandom_range(0, k + 1))
                begin
                    if (sounding_total != 0 && $urandom_range(0, 4) != 0)
                        n = sounding_note[$urandom_range(0, sounding_total - 1)];
                    else
                        n = 7'($urandom);
                    if ($urandom_range(0, 2) == 0)
                        send_item(ancb_pkg::CMD_NOTE_ON, n, 7'd0, 1'b1);
                    else
                        send_item(ancb_pkg::CMD_NOTE_OFF, n, 7'($urandom), 1'b1);
                end
                if ($urandom_range(0, 1) == 1)
                    send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
            end
            else if (kind < 17)
            begin
                repeat (4)
                    send_item(ancb_pkg::cmd_t'($urandom_range(0, 3)), 7'($urandom),
                              7'($urandom), 1'b1);
            end
            else
            begin
                send_item(ancb_pkg::CMD_CLEAR, 7'($urandom), 7'($urandom), 1'b1);
                send_item(ancb_pkg::CMD_QUERY, 7'($urandom), 7'($urandom), 1'b1);
            end
        end
        drain_results();

        if (mismatches == 0)
            $display("active_note_chroma_builder_unit verification clean");
        else
            $display("active_note_chroma_builder_unit verification failed");
        $finish;
    end

    // chroma receiver and checker
    initial
    begin
        int unsigned       stall;
        ancb_pkg::chroma_t want;
        bin_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                bin_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = draw_wait(recv_calm);
            if (stall != 0)
            begin
                bin_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            bin_ch.ready <= 1'b1;
            do @(posedge clk); while (bin_ch.valid !== 1'b1);
            if (pending_bins.size() == 0)
            begin
                $display("%0t ns: chroma transfer expected none, got class %0d weight %0d",
                         $time, bin_ch.data.pitch_class, bin_ch.data.weight_sum);
                mismatches++;
            end
            else
            begin
                want = pending_bins.pop_front();
                check_field("pitch_class", want.pitch_class, bin_ch.data.pitch_class);
                check_field("weight_sum", want.weight_sum, bin_ch.data.weight_sum);
                check_field("bass_class", want.bass_class, bin_ch.data.bass_class);
                check_field("note_count", want.note_count, bin_ch.data.note_count);
                check_field("overflow", want.overflow, bin_ch.data.overflow);
                check_field("last", want.last, bin_ch.data.last);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (bin_ch.valid && bin_ch.ready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("active_note_chroma_builder_unit verification failed");
                $finish;
            end
        end
    end

endmodule

/* files.f */
hdl/ancb_pkg.sv
hdl/ancb_msg_if.sv
hdl/ancb_chroma_if.sv
hdl/ancb_chroma_acc.sv
hdl/active_note_chroma_builder_unit.sv
tb/active_note_chroma_builder_unit_test.sv
